/* rtl/mdbt_pkg.sv */
// Package for the market data book and trade statistics unit.
// Holds the action codes, the beat payload types, the storage entry types
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package mdbt_pkg;

  localparam logic [3:0] ACT_QUOTE    = 4'd0;
  localparam logic [3:0] ACT_SIDE     = 4'd1;
  localparam logic [3:0] ACT_TRADE    = 4'd2;
  localparam logic [3:0] ACT_TOP_APX  = 4'd3;
  localparam logic [3:0] ACT_TOP_ASZ  = 4'd4;
  localparam logic [3:0] ACT_TOP_BPX  = 4'd5;
  localparam logic [3:0] ACT_TOP_BSZ  = 4'd6;
  localparam logic [3:0] ACT_LAST_PX  = 4'd7;
  localparam logic [3:0] ACT_LAST_SZ  = 4'd8;
  localparam logic [3:0] ACT_MID      = 4'd9;

  // numerator of the VWAP update: volume*vwap + close*qty stays below 2^81
  localparam int NUMW = 81;
  localparam int DENW = 49;
  localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  action;
    logic [9:0]  sec_id;
    logic [2:0]  level;
    logic        is_bid;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] lvl_bid_px;
    logic [31:0] lvl_bid_qty;
    logic [31:0] lvl_ask_px;
    logic [31:0] lvl_ask_qty;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  out_sec_id;
    logic        notify;
    logic [31:0] top_bid_px;
    logic [31:0] top_bid_qty;
    logic [31:0] top_ask_px;
    logic [31:0] top_ask_qty;
    logic [31:0] open_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;
    logic [31:0] avg_price;
    logic [47:0] total_volume;
  } out_item_t;

  typedef struct packed {
    logic [31:0] bid_px;
    logic [31:0] bid_sz;
    logic [31:0] ask_px;
    logic [31:0] ask_sz;
  } book_t;

  typedef struct packed {
    logic [31:0] open;
    logic [31:0] high;
    logic [31:0] low;
    logic [31:0] close;
    logic [31:0] vwap;
    logic [47:0] volume;
  } stat_t;

  typedef struct packed {
    logic       clr;
    logic       capture;
    logic       rd_item;
    logic       rd_top;
    logic       apply;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       div_init;
    logic       div_step;
    logic       fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic vol_go;
  } dp_sts_t;

endpackage

/* rtl/mdbt_stream_if.sv */
// Valid/ready stream channel carrying one payload per beat.
// Payload type is set at instantiation; no other dependencies.
`timescale 1ns / 1ps

interface mdbt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mdbt_ctrl.sv */
// Sequencer for the book/stats unit: clearing pass, read, apply,
// multiply and divide steps, result hand-off. Uses mdbt_pkg.
`timescale 1ns / 1ps

module mdbt_ctrl
  import mdbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIVI  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_top = 1'b1;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.vol_go ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = cnt_r[1:0];
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (load) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/mdbt_dp.sv */
// Datapath for the book/stats unit: book and stats memories, update
// logic, shared 32x32 multiplier and radix-2 VWAP divider. Uses mdbt_pkg.
`timescale 1ns / 1ps

module mdbt_dp
  import mdbt_pkg::*;
#(
  parameter int LEVELS     = 5,
  parameter int SECURITIES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_sts_t    sts,
  input  in_item_t   in_item,
  output out_item_t  out_item
);

  localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SAW    = (SECURITIES > 1) ? $clog2(SECURITIES) : 1;
  localparam int BAW    = SAW + LVW;
  localparam int BDEPTH = SECURITIES << LVW;

  book_t book_mem [BDEPTH];
  stat_t stat_mem [SECURITIES];

  in_item_t        item_r;
  book_t           book_rd_r, lvl_r, top_r;
  stat_t           stat_rd_r, st_r;
  logic            notify_r, vol_go_r;
  logic [31:0]     q_r;
  logic [63:0]     p_r;
  logic            psh_r;
  logic [NUMW-1:0] acc_r;
  logic [DENW-1:0] rem_r, den_r;
  logic [31:0]     lo_r;
  logic [BAW-1:0]  ca_r;
  out_item_t       out_r;
  out_item_t       out_nxt;

  logic [SAW-1:0]  sec_a;
  logic [LVW-1:0]  lvl_a;
  logic [BAW-1:0]  book_ra, book_wa;
  logic            book_we, stat_we;
  book_t           book_wd;
  logic [SAW-1:0]  stat_wa;
  stat_t           stat_wd;
  logic            oor, lvl_ok, lvl0;

  book_t           top_rd, wr_val, top_new;
  logic            wr_top, wr_en;
  stat_t           st_new;
  logic            notify, vol_go, px_go;
  logic [31:0]     px_val, q_val;
  logic [32:0]     mid_sum;
  logic [31:0]     ma, mb;
  logic [DENW:0]   rem2;
  logic            ge;
  stat_t           st_fin;

  function automatic stat_t price_rule(stat_t s, logic [31:0] p);
    stat_t r;
    r = s;
    if (s.open == 32'd0) r.open = p;
    if (p > s.high) r.high = p;
    if (p < s.low || s.low == 32'd0) r.low = p;
    r.close = p;
    return r;
  endfunction

  assign sec_a  = SAW'(item_r.sec_id);
  assign lvl_a  = LVW'(item_r.level);
  assign oor    = 32'(item_r.sec_id) >= SECURITIES;
  assign lvl_ok = 32'(item_r.level) < LEVELS;
  assign lvl0   = (item_r.level == 3'd0);

  // first read is the addressed level, second is the top of book
  assign book_ra = cmd.rd_top ? {sec_a, {LVW{1'b0}}} : {sec_a, lvl_a};

  assign top_rd  = book_rd_r;
  assign mid_sum = {1'b0, top_rd.ask_px} + {1'b0, top_rd.bid_px};

  always_comb begin
    wr_en  = 1'b0;
    wr_top = 1'b0;
    wr_val = top_rd;
    notify = 1'b0;
    vol_go = 1'b0;
    px_go  = 1'b0;
    px_val = item_r.price;
    q_val  = item_r.qty;
    case (item_r.action)
      ACT_QUOTE: begin
        wr_en  = lvl_ok;
        wr_top = lvl0;
        wr_val = '{bid_px: item_r.lvl_bid_px, bid_sz: item_r.lvl_bid_qty,
                   ask_px: item_r.lvl_ask_px, ask_sz: item_r.lvl_ask_qty};
        notify = lvl_ok && lvl0;
      end
      ACT_SIDE: begin
        wr_en  = lvl_ok;
        wr_top = lvl0;
        wr_val = lvl_r;
        if (item_r.is_bid) begin
          wr_val.bid_px = item_r.price;
          wr_val.bid_sz = item_r.qty;
        end else begin
          wr_val.ask_px = item_r.price;
          wr_val.ask_sz = item_r.qty;
        end
        notify = lvl_ok && lvl0;
      end
      ACT_TRADE: begin
        px_go  = (item_r.price != 32'd0);
        vol_go = (item_r.qty != 32'd0);
        notify = 1'b1;
      end
      ACT_TOP_APX, ACT_TOP_ASZ, ACT_TOP_BPX, ACT_TOP_BSZ: begin
        wr_en  = 1'b1;
        wr_top = 1'b1;
        if (item_r.action == ACT_TOP_APX) wr_val.ask_px = item_r.price;
        if (item_r.action == ACT_TOP_ASZ) wr_val.ask_sz = item_r.price;
        if (item_r.action == ACT_TOP_BPX) wr_val.bid_px = item_r.price;
        if (item_r.action == ACT_TOP_BSZ) wr_val.bid_sz = item_r.price;
        notify = 1'b1;
      end
      ACT_LAST_PX: begin
        px_go  = (item_r.price != 32'd0);
        notify = px_go;
      end
      ACT_LAST_SZ: begin
        vol_go = (item_r.price != 32'd0);
        q_val  = item_r.price;
        notify = vol_go;
      end
      ACT_MID: begin
        px_go  = (top_rd.ask_px > top_rd.bid_px) && (top_rd.bid_px != 32'd0);
        px_val = mid_sum[32:1];
        notify = px_go;
      end
      default: ;
    endcase
    if (oor) begin
      wr_en  = 1'b0;
      px_go  = 1'b0;
      vol_go = 1'b0;
      notify = 1'b0;
    end
  end

  assign top_new = (wr_en && wr_top) ? wr_val : top_rd;
  assign st_new  = px_go ? price_rule(st_r, px_val) : st_r;

  assign sts.vol_go   = vol_go;
  assign sts.clr_done = (ca_r == BAW'(BDEPTH - 1));

  // book write: clearing pass or the update of one level
  always_comb begin
    book_we = 1'b0;
    book_wa = wr_top ? {sec_a, {LVW{1'b0}}} : {sec_a, lvl_a};
    book_wd = wr_val;
    if (cmd.clr) begin
      book_we = 1'b1;
      book_wa = ca_r;
      book_wd = '0;
    end else if (cmd.apply && wr_en) begin
      book_we = 1'b1;
    end
  end

  always_comb begin
    st_fin = st_r;
    if (vol_go_r) begin
      st_fin.vwap   = lo_r;
      st_fin.volume = (den_r > {1'b0, VOL_MAX}) ? VOL_MAX : den_r[47:0];
    end
  end

  always_comb begin
    stat_we = 1'b0;
    stat_wa = sec_a;
    stat_wd = st_fin;
    if (cmd.clr) begin
      stat_we = 1'b1;
      stat_wa = ca_r[BAW-1:LVW];
      stat_wd = '0;
    end else if (cmd.fin && !oor) begin
      stat_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (book_we) book_mem[book_wa] <= book_wd;
    book_rd_r <= book_mem[book_ra];
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    stat_rd_r <= stat_mem[sec_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ca_r <= '0;
    else if (cmd.clr && !sts.clr_done) ca_r <= ca_r + BAW'(1);
  end

  // multiplier operands: volume low word, volume high word, then qty*close
  always_comb begin
    ma = st_r.volume[31:0];
    mb = st_r.vwap;
    case (cmd.mul_step)
      2'd1:    ma = {16'd0, st_r.volume[47:32]};
      2'd2: begin
        ma = q_r;
        mb = st_r.close;
      end
      default: ;
    endcase
  end

  assign rem2 = {rem_r, lo_r[31]};
  assign ge   = rem2 >= {1'b0, den_r};

  // unknown security shows only its id
  always_comb begin
    out_nxt = '0;
    out_nxt.out_sec_id = item_r.sec_id;
    if (!oor) begin
      out_nxt.notify       = notify_r;
      out_nxt.top_bid_px   = top_r.bid_px;
      out_nxt.top_bid_qty  = top_r.bid_sz;
      out_nxt.top_ask_px   = top_r.ask_px;
      out_nxt.top_ask_qty  = top_r.ask_sz;
      out_nxt.open_price   = st_fin.open;
      out_nxt.high_price   = st_fin.high;
      out_nxt.low_price    = st_fin.low;
      out_nxt.close_price  = st_fin.close;
      out_nxt.avg_price    = st_fin.vwap;
      out_nxt.total_volume = st_fin.volume;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.rd_top) begin
      lvl_r <= book_rd_r;
      st_r  <= stat_rd_r;
    end
    if (cmd.apply) begin
      top_r    <= top_new;
      st_r     <= st_new;
      notify_r <= notify;
      vol_go_r <= vol_go;
      q_r      <= q_val;
    end
    if (cmd.mul_en) begin
      p_r   <= 64'(ma) * 64'(mb);
      psh_r <= (cmd.mul_step == 2'd1);
      if (cmd.mul_step == 2'd0) acc_r <= '0;
      else acc_r <= acc_r + (psh_r ? {p_r[48:0], 32'd0} : NUMW'(p_r));
    end
    if (cmd.div_init) begin
      rem_r <= acc_r[NUMW-1:32];
      lo_r  <= acc_r[31:0];
      den_r <= {1'b0, st_r.volume} + DENW'(q_r);
    end
    if (cmd.div_step) begin
      rem_r <= ge ? DENW'(rem2 - {1'b0, den_r}) : rem2[DENW-1:0];
      lo_r  <= {lo_r[30:0], ge};
    end
    if (cmd.fin) out_r <= out_nxt;
  end

  assign out_item = out_r;

endmodule

/* rtl/market_data_book_and_trade_stats_unit.sv */
// Channel    Dir  Payload                        Beat taken when
// in_ch      in   in_item_t (update message)     in_ch.valid && in_ch.ready
// out_ch     out  out_item_t (top + statistics)  out_ch.valid && out_ch.ready
//
// One message at a time: after it is taken a message passes the read, apply
// and result states; items with a quantity also pass 4 multiply steps on one
// 32x32 multiplier, a divider load and 32 radix-2 VWAP divide steps.
// in_ch.ready returns as the result is loaded into the output register.
// After reset a clearing pass over every book address zeroes the book and
// statistics memories; in_ch.ready stays low meanwhile.
// A stalled result holds in the output register; the next message is
// taken while it waits and its result holds until the register frees.
// Top level: joins mdbt_ctrl and mdbt_dp; uses mdbt_pkg and mdbt_stream_if.
`timescale 1ns / 1ps

module market_data_book_and_trade_stats_unit
  import mdbt_pkg::*;
#(
  parameter int LEVELS     = 5,
  parameter int SECURITIES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  mdbt_stream_if.sink   in_ch,
  mdbt_stream_if.source out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  in_item_t  in_item;
  out_item_t out_item;

  assign in_item     = in_ch.data;
  assign out_ch.data = out_item;

  mdbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mdbt_dp #(
    .LEVELS     (LEVELS),
    .SECURITIES (SECURITIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

/* rtl/mdbt_checker.sv */
// Port-level checks for the book/stats unit, bound to the top level.
// Depends on the top level's clock, reset, channel ports and SECURITIES only.
`timescale 1ns / 1ps

module mdbt_checker #(
  parameter int SECURITIES = 1024
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_sec_id,
  input logic        notify,
  input logic [31:0] top_bid_px,
  input logic [31:0] open_price,
  input logic [31:0] high_price,
  input logic [31:0] low_price
);

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  // one message at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second message accepted while busy");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (32'(out_sec_id) >= SECURITIES) |->
      !notify && top_bid_px == 32'd0 && open_price == 32'd0)
    else $error("unknown security shows data");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && low_price != 32'd0 |->
      low_price <= high_price && open_price != 32'd0)
    else $error("trade range inconsistent");

endmodule

bind market_data_book_and_trade_stats_unit mdbt_checker #(
  .SECURITIES (SECURITIES)
) u_mdbt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_sec_id    (out_ch.data.out_sec_id),
  .notify        (out_ch.data.notify),
  .top_bid_px    (out_ch.data.top_bid_px),
  .open_price    (out_ch.data.open_price),
  .high_price    (out_ch.data.high_price),
  .low_price     (out_ch.data.low_price)
);
